### rtl/pge_pkg.sv
// shared types, widths and codes for the pairwise gravity euler step block
`default_nettype none
package pge_pkg;

  localparam int BODY_COUNT = 64;
  localparam int IDX_W      = $clog2(BODY_COUNT);
  localparam int ACC_W      = 48;
  localparam int DIV_W      = 64;
  localparam int SQRT_W     = 64;
  localparam int ROOT_W     = SQRT_W / 2;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_PAIR = 2'd1;
  localparam logic [1:0] MODE_STEP = 2'd2;
  localparam logic [1:0] MODE_READ = 2'd3;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_COINCIDENT = 2'd1;
  localparam logic [1:0] STATUS_SATURATED  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         first_index;
    logic [5:0]         second_index;
    logic [31:0]        load_mass;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic [15:0]        time_step;
  } pge_in_t;

  typedef struct packed {
    logic [5:0]         body_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [1:0]         status;
  } pge_out_t;

  typedef struct packed {
    logic [31:0] mass;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
  } pge_body_t;

  typedef struct packed {
    logic [ACC_W-1:0] x;
    logic [ACC_W-1:0] y;
  } pge_acc_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] hi;
    logic [DIV_W-1:0] lo;
    logic [DIV_W-1:0] den;
  } pge_div_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [DIV_W-1:0] quo;
  } pge_div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [SQRT_W-1:0] rad;
  } pge_sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } pge_sqrt_rsp_t;

endpackage
`default_nettype wire

### rtl/pairwise_gravity_euler_step.sv
// top level: body table, pair gravity, semi-implicit euler step, q16.16
//
//  channel  ports                     handshake
//  input    start, busy, in_data      taken at an edge with start high, busy low
//  result   out_valid, out_data       one word per item, one cycle, no stall
//  config   cfg_we, cfg_wdata         gravity constant, written when cfg_we high
//
// an item holds busy until its result; busy falls in the cycle that carries the strobe
// a pair is the longest item; its length is set by
// the shared bit-serial divider (eight 64-step divides) after a 32-step square root
// reset clears control and the accumulator valid bits; body entries stay unknown
// until loaded, an accumulator that was never written reads as zero
`default_nettype none
module pairwise_gravity_euler_step (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  pge_pkg::pge_in_t  in_data,
  output logic              out_valid,
  output pge_pkg::pge_out_t out_data,
  input  wire               cfg_we,
  input  wire [31:0]        cfg_wdata
);
  import pge_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_RD_I, S_RD_J, S_CAP_J, S_DIFF, S_SQ, S_GM,
    S_SQRT_GO, S_SQRT_WAIT, S_PLO, S_PHI, S_PSUM, S_DIV1_GO, S_DIV1_WAIT,
    S_DIV2_GO, S_DIV2_WAIT, S_ACC_I, S_ACC_J, S_VEL, S_VEL_SUM, S_POS,
    S_POS_SUM, S_DONE
  } state_t;

  localparam logic [63:0]      S_CAP   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]      A_CAP   = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [31:0]      W_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0]      W_MIN   = 32'h8000_0000;
  localparam logic [31:0]      D_NEG   = 32'h8000_0001;

  // |v|*dt >> 16 with the sign of v put back
  function automatic logic [ACC_W:0] scale_acc(input logic [ACC_W-1:0] v,
                                               input logic [15:0] dt);
    logic [ACC_W-1:0] mag;
    logic [63:0]      prod;
    logic [ACC_W:0]   p;
    mag  = v[ACC_W-1] ? (ACC_W'(0) - v) : v;
    prod = 64'(mag) * 64'(dt);
    p    = {1'b0, prod[63:16]};
    return v[ACC_W-1] ? ((ACC_W+1)'(0) - p) : p;
  endfunction

  function automatic logic [32:0] scale_vel(input logic [31:0] v,
                                            input logic [15:0] dt);
    logic [31:0] mag;
    logic [47:0] prod;
    logic [32:0] p;
    mag  = v[31] ? (32'd0 - v) : v;
    prod = 48'(mag) * 48'(dt);
    p    = {1'b0, prod[47:16]};
    return v[31] ? (33'd0 - p) : p;
  endfunction

  // control
  state_t      state_r;
  logic [1:0]  part_r;
  logic        sat_r;
  logic        coin_r;
  logic        out_valid_r;
  pge_out_t    out_r;
  logic [31:0] grav_r;

  // datapath
  pge_in_t          in_r;
  pge_body_t        bi_r;
  pge_body_t        bj_r;
  pge_acc_t         ai_r;
  pge_acc_t         aj_r;
  logic [31:0]      dx_r;
  logic [31:0]      dy_r;
  logic [61:0]      dx2_r;
  logic [61:0]      dy2_r;
  logic [63:0]      r2_r;
  logic [ROOT_W-1:0] r_r;
  logic [63:0]      gm1_r;
  logic [63:0]      gm2_r;
  logic [63:0]      plo_r;
  logic [63:0]      phi_r;
  logic [95:0]      prod_r;
  logic [63:0]      s_r;
  logic [ACC_W-1:0] apart_r [4];
  logic [ACC_W:0]   tvx_r;
  logic [ACC_W:0]   tvy_r;
  logic [32:0]      tpx_r;
  logic [32:0]      tpy_r;

  // memories
  pge_body_t        body_mem [BODY_COUNT];
  pge_acc_t         acc_mem  [BODY_COUNT];
  pge_body_t        body_rd_r;
  pge_acc_t         acc_rd_r;
  logic             acc_rvld_r;
  logic [BODY_COUNT-1:0] acc_vld_r;

  logic             bm_re;
  logic             bm_we;
  logic [IDX_W-1:0] bm_raddr;
  logic [IDX_W-1:0] bm_waddr;
  pge_body_t        bm_wdata;
  logic             am_re;
  logic             am_we;
  logic [IDX_W-1:0] am_raddr;
  logic [IDX_W-1:0] am_waddr;
  pge_acc_t         am_wdata;

  pge_div_req_t  div_req;
  pge_div_rsp_t  div_rsp;
  pge_sqrt_req_t sqrt_req;
  pge_sqrt_rsp_t sqrt_rsp;

  logic             accept_s;
  logic [IDX_W-1:0] i_s;
  logic [IDX_W-1:0] j_s;
  pge_acc_t         acc_rd_s;
  pge_body_t        load_s;
  logic [32:0]      dxw_s;
  logic [32:0]      dyw_s;
  logic             dx_hi_s, dx_lo_s, dy_hi_s, dy_lo_s;
  logic [31:0]      dxa_s;
  logic [31:0]      dya_s;
  logic [30:0]      mdx_s;
  logic [30:0]      mdy_s;
  logic [63:0]      gm_sel_s;
  logic [30:0]      mag_sel_s;
  logic             s_cap_s;
  logic             a_cap_s;
  logic             neg_s;
  logic [ACC_W-1:0] amag_s;
  pge_acc_t         acc_base_s;
  logic [ACC_W-1:0] add_x_s;
  logic [ACC_W-1:0] add_y_s;
  logic [ACC_W:0]   sum_x_s;
  logic [ACC_W:0]   sum_y_s;
  logic             sum_x_ovf_s, sum_y_ovf_s;
  pge_acc_t         acc_new_s;
  logic [49:0]      vsx_s;
  logic [49:0]      vsy_s;
  logic             vx_ovf_s, vy_ovf_s;
  logic [31:0]      vx_new_s;
  logic [31:0]      vy_new_s;
  logic [33:0]      psx_s;
  logic [33:0]      psy_s;
  logic             px_ovf_s, py_ovf_s;
  logic [31:0]      px_new_s;
  logic [31:0]      py_new_s;
  logic             sat_set_s;

  assign busy     = (state_r != S_IDLE);
  assign accept_s = start && !busy;
  assign i_s      = in_r.first_index[IDX_W-1:0];
  assign j_s      = in_r.second_index[IDX_W-1:0];
  assign acc_rd_s = acc_rvld_r ? acc_rd_r : '0;

  assign load_s.mass  = in_r.load_mass;
  assign load_s.pos_x = in_r.load_pos_x;
  assign load_s.pos_y = in_r.load_pos_y;
  assign load_s.vel_x = in_r.load_vel_x;
  assign load_s.vel_y = in_r.load_vel_y;

  // separation, clamped to +-(2^31-1)
  assign dxw_s   = {bj_r.pos_x[31], bj_r.pos_x} - {bi_r.pos_x[31], bi_r.pos_x};
  assign dyw_s   = {bj_r.pos_y[31], bj_r.pos_y} - {bi_r.pos_y[31], bi_r.pos_y};
  assign dx_hi_s = !dxw_s[32] && dxw_s[31];
  assign dx_lo_s = dxw_s[32] && (dxw_s[31:0] <= W_MIN);
  assign dy_hi_s = !dyw_s[32] && dyw_s[31];
  assign dy_lo_s = dyw_s[32] && (dyw_s[31:0] <= W_MIN);

  assign dxa_s = dx_r[31] ? (32'd0 - dx_r) : dx_r;
  assign dya_s = dy_r[31] ? (32'd0 - dy_r) : dy_r;
  assign mdx_s = dxa_s[30:0];
  assign mdy_s = dya_s[30:0];

  // parts: 0 first x, 1 first y, 2 second x, 3 second y
  assign gm_sel_s  = part_r[1] ? gm2_r : gm1_r;
  assign mag_sel_s = part_r[0] ? mdy_s : mdx_s;
  assign neg_s     = (part_r[0] ? dy_r[31] : dx_r[31]) ^ part_r[1];
  assign s_cap_s   = div_rsp.ovf || div_rsp.quo[63];
  assign a_cap_s   = div_rsp.ovf || (div_rsp.quo > A_CAP);
  assign amag_s    = a_cap_s ? ACC_MAX : div_rsp.quo[ACC_W-1:0];

  assign acc_base_s  = (state_r == S_ACC_J) ? aj_r : ai_r;
  assign add_x_s     = (state_r == S_ACC_J) ? apart_r[2] : apart_r[0];
  assign add_y_s     = (state_r == S_ACC_J) ? apart_r[3] : apart_r[1];
  assign sum_x_s     = {acc_base_s.x[ACC_W-1], acc_base_s.x} + {add_x_s[ACC_W-1], add_x_s};
  assign sum_y_s     = {acc_base_s.y[ACC_W-1], acc_base_s.y} + {add_y_s[ACC_W-1], add_y_s};
  assign sum_x_ovf_s = sum_x_s[ACC_W] ^ sum_x_s[ACC_W-1];
  assign sum_y_ovf_s = sum_y_s[ACC_W] ^ sum_y_s[ACC_W-1];
  assign acc_new_s.x = sum_x_ovf_s ? (sum_x_s[ACC_W] ? ACC_MIN : ACC_MAX)
                                   : sum_x_s[ACC_W-1:0];
  assign acc_new_s.y = sum_y_ovf_s ? (sum_y_s[ACC_W] ? ACC_MIN : ACC_MAX)
                                   : sum_y_s[ACC_W-1:0];

  assign vsx_s    = {{18{bi_r.vel_x[31]}}, bi_r.vel_x} + {tvx_r[ACC_W], tvx_r};
  assign vsy_s    = {{18{bi_r.vel_y[31]}}, bi_r.vel_y} + {tvy_r[ACC_W], tvy_r};
  assign vx_ovf_s = vsx_s != {{18{vsx_s[31]}}, vsx_s[31:0]};
  assign vy_ovf_s = vsy_s != {{18{vsy_s[31]}}, vsy_s[31:0]};
  assign vx_new_s = vx_ovf_s ? (vsx_s[49] ? W_MIN : W_MAX) : vsx_s[31:0];
  assign vy_new_s = vy_ovf_s ? (vsy_s[49] ? W_MIN : W_MAX) : vsy_s[31:0];

  assign psx_s    = {{2{bi_r.pos_x[31]}}, bi_r.pos_x} + {tpx_r[32], tpx_r};
  assign psy_s    = {{2{bi_r.pos_y[31]}}, bi_r.pos_y} + {tpy_r[32], tpy_r};
  assign px_ovf_s = psx_s != {{2{psx_s[31]}}, psx_s[31:0]};
  assign py_ovf_s = psy_s != {{2{psy_s[31]}}, psy_s[31:0]};
  assign px_new_s = px_ovf_s ? (psx_s[33] ? W_MIN : W_MAX) : psx_s[31:0];
  assign py_new_s = py_ovf_s ? (psy_s[33] ? W_MIN : W_MAX) : psy_s[31:0];

  always_comb begin
    sat_set_s = 1'b0;
    case (state_r)
      S_DIFF:           sat_set_s = dx_hi_s || dx_lo_s || dy_hi_s || dy_lo_s;
      S_DIV1_WAIT:      sat_set_s = div_rsp.done && s_cap_s;
      S_DIV2_WAIT:      sat_set_s = div_rsp.done && a_cap_s;
      S_ACC_I, S_ACC_J: sat_set_s = sum_x_ovf_s || sum_y_ovf_s;
      S_VEL_SUM:        sat_set_s = vx_ovf_s || vy_ovf_s;
      S_POS_SUM:        sat_set_s = px_ovf_s || py_ovf_s;
      default:          sat_set_s = 1'b0;
    endcase
  end

  // memory port control
  always_comb begin
    bm_re    = 1'b0;
    bm_we    = 1'b0;
    bm_raddr = i_s;
    bm_waddr = i_s;
    bm_wdata = load_s;
    am_re    = 1'b0;
    am_we    = 1'b0;
    am_raddr = i_s;
    am_waddr = i_s;
    am_wdata = '0;
    unique case (state_r)
      S_LOAD: begin
        bm_we = 1'b1;
        am_we = 1'b1;
      end
      S_RD_I: begin
        bm_re = 1'b1;
        am_re = 1'b1;
      end
      S_RD_J: begin
        bm_re    = 1'b1;
        am_re    = 1'b1;
        bm_raddr = j_s;
        am_raddr = j_s;
      end
      S_ACC_I: begin
        am_we    = 1'b1;
        am_wdata = acc_new_s;
      end
      S_ACC_J: begin
        am_we    = 1'b1;
        am_waddr = j_s;
        am_wdata = acc_new_s;
      end
      S_POS_SUM: begin
        bm_we          = 1'b1;
        bm_wdata       = bi_r;
        bm_wdata.pos_x = px_new_s;
        bm_wdata.pos_y = py_new_s;
        am_we          = 1'b1;
      end
      default: begin
        bm_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (bm_we) body_mem[bm_waddr] <= bm_wdata;
    if (bm_re) body_rd_r <= body_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (am_we) acc_mem[am_waddr] <= am_wdata;
    if (am_re) acc_rd_r <= acc_mem[am_raddr];
  end

  // accumulator valid bits stand in for the all-zero reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r  <= '0;
      acc_rvld_r <= 1'b0;
    end else begin
      if (am_we) acc_vld_r[am_waddr] <= 1'b1;
      if (am_re) acc_rvld_r <= acc_vld_r[am_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= 32'h0001_0000;
    end else if (cfg_we) begin
      grav_r <= cfg_wdata;
    end
  end

  pge_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  pge_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign sqrt_req.start = (state_r == S_SQRT_GO);
  assign sqrt_req.rad   = r2_r;

  always_comb begin
    div_req.start = 1'b0;
    div_req.hi    = {32'd0, prod_r[95:64]};
    div_req.lo    = prod_r[63:0];
    div_req.den   = r2_r;
    if (state_r == S_DIV1_GO) begin
      div_req.start = 1'b1;
    end else if (state_r == S_DIV2_GO) begin
      div_req.start = 1'b1;
      div_req.hi    = {48'd0, s_r[63:48]};
      div_req.lo    = {s_r[47:0], 16'd0};
      div_req.den   = {32'd0, r_r};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept_s) in_r <= in_data;
      end
      S_LOAD: bi_r <= load_s;
      S_RD_J: begin
        bi_r <= body_rd_r;
        ai_r <= acc_rd_s;
      end
      S_CAP_J: begin
        bj_r <= body_rd_r;
        aj_r <= acc_rd_s;
      end
      S_DIFF: begin
        dx_r <= dx_hi_s ? W_MAX : (dx_lo_s ? D_NEG : dxw_s[31:0]);
        dy_r <= dy_hi_s ? W_MAX : (dy_lo_s ? D_NEG : dyw_s[31:0]);
      end
      S_SQ: begin
        dx2_r <= 62'(mdx_s) * 62'(mdx_s);
        dy2_r <= 62'(mdy_s) * 62'(mdy_s);
      end
      S_GM: begin
        r2_r  <= 64'(dx2_r) + 64'(dy2_r);
        gm1_r <= 64'(grav_r) * 64'(bj_r.mass);
        gm2_r <= 64'(grav_r) * 64'(bi_r.mass);
      end
      S_SQRT_WAIT: begin
        if (sqrt_rsp.done) r_r <= sqrt_rsp.root;
      end
      S_PLO:  plo_r <= 64'(gm_sel_s[31:0]) * 64'(mag_sel_s);
      S_PHI:  phi_r <= 64'(gm_sel_s[63:32]) * 64'(mag_sel_s);
      S_PSUM: prod_r <= {32'd0, plo_r} + {phi_r, 32'd0};
      S_DIV1_WAIT: begin
        if (div_rsp.done) s_r <= s_cap_s ? S_CAP : div_rsp.quo;
      end
      S_DIV2_WAIT: begin
        if (div_rsp.done) apart_r[part_r] <= neg_s ? (ACC_W'(0) - amag_s) : amag_s;
      end
      S_VEL: begin
        tvx_r <= scale_acc(ai_r.x, in_r.time_step);
        tvy_r <= scale_acc(ai_r.y, in_r.time_step);
      end
      S_VEL_SUM: begin
        bi_r.vel_x <= vx_new_s;
        bi_r.vel_y <= vy_new_s;
      end
      S_POS: begin
        tpx_r <= scale_vel(bi_r.vel_x, in_r.time_step);
        tpy_r <= scale_vel(bi_r.vel_y, in_r.time_step);
      end
      S_POS_SUM: begin
        bi_r.pos_x <= px_new_s;
        bi_r.pos_y <= py_new_s;
      end
      default: ;
    endcase
  end

  // sequencer and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      part_r      <= '0;
      sat_r       <= 1'b0;
      coin_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (sat_set_s) sat_r <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (accept_s) begin
            sat_r   <= 1'b0;
            coin_r  <= 1'b0;
            state_r <= (in_data.mode == MODE_LOAD) ? S_LOAD : S_RD_I;
          end
        end
        S_LOAD: state_r <= S_DONE;
        S_RD_I: state_r <= S_RD_J;
        S_RD_J: begin
          if (in_r.mode == MODE_PAIR) begin
            state_r <= S_CAP_J;
          end else if (in_r.mode == MODE_STEP) begin
            state_r <= S_VEL;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_CAP_J: state_r <= S_DIFF;
        S_DIFF:  state_r <= S_SQ;
        S_SQ: begin
          if ((i_s == j_s) || ((dx_r == '0) && (dy_r == '0))) begin
            coin_r  <= 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_GM;
          end
        end
        S_GM: begin
          part_r  <= '0;
          state_r <= S_SQRT_GO;
        end
        S_SQRT_GO: state_r <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (sqrt_rsp.done) state_r <= S_PLO;
        end
        S_PLO:     state_r <= S_PHI;
        S_PHI:     state_r <= S_PSUM;
        S_PSUM:    state_r <= S_DIV1_GO;
        S_DIV1_GO: state_r <= S_DIV1_WAIT;
        S_DIV1_WAIT: begin
          if (div_rsp.done) state_r <= S_DIV2_GO;
        end
        S_DIV2_GO: state_r <= S_DIV2_WAIT;
        S_DIV2_WAIT: begin
          if (div_rsp.done) begin
            part_r  <= part_r + 1'b1;
            state_r <= (part_r == 2'd3) ? S_ACC_I : S_PLO;
          end
        end
        S_ACC_I:   state_r <= S_ACC_J;
        S_ACC_J:   state_r <= S_DONE;
        S_VEL:     state_r <= S_VEL_SUM;
        S_VEL_SUM: state_r <= S_POS;
        S_POS:     state_r <= S_POS_SUM;
        S_POS_SUM: state_r <= S_DONE;
        S_DONE: begin
          out_valid_r      <= 1'b1;
          out_r.body_index <= 6'(i_s);
          out_r.pos_x      <= bi_r.pos_x;
          out_r.pos_y      <= bi_r.pos_y;
          out_r.vel_x      <= bi_r.vel_x;
          out_r.vel_y      <= bi_r.vel_y;
          out_r.status     <= coin_r ? STATUS_COINCIDENT :
                              (sat_r ? STATUS_SATURATED : STATUS_OK);
          state_r          <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept_s |=> busy)
    else $error("accepted word did not raise busy");

  a_pair_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC_J) |-> (i_s != j_s))
    else $error("pair accumulate on the same body");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (bm_we || am_we) |-> busy)
    else $error("table write while idle");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_coin_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STATUS_COINCIDENT)) |-> (in_r.mode == MODE_PAIR))
    else $error("coincident status outside pair mode");

endmodule
`default_nettype wire

### rtl/pge_div.sv
// bit-serial restoring divider: floor({hi,lo}/den), flags hi >= den
`default_nettype none
module pge_div (
  input  wire                   clk,
  input  wire                   rst_n,
  input  pge_pkg::pge_div_req_t req,
  output pge_pkg::pge_div_rsp_t rsp
);
  import pge_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             run_r;
  logic             done_r;
  logic             ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] num_r;
  logic [DIV_W-1:0] den_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W:0]   shift_s;
  logic [DIV_W:0]   diff_s;
  logic             fit_s;

  assign shift_s = {rem_r, num_r[DIV_W-1]};
  assign diff_s  = shift_s - {1'b0, den_r};
  assign fit_s   = shift_s >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !run_r) begin
        cnt_r <= '0;
        if (req.hi >= req.den) begin
          // quotient would not fit
          ovf_r  <= 1'b1;
          done_r <= 1'b1;
        end else begin
          ovf_r <= 1'b0;
          run_r <= 1'b1;
        end
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !run_r) begin
      rem_r <= req.hi;
      num_r <= req.lo;
      den_r <= req.den;
      quo_r <= '0;
    end else if (run_r) begin
      rem_r <= fit_s ? diff_s[DIV_W-1:0] : shift_s[DIV_W-1:0];
      num_r <= {num_r[DIV_W-2:0], 1'b0};
      quo_r <= {quo_r[DIV_W-2:0], fit_s};
    end
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.quo  = quo_r;

endmodule
`default_nettype wire

### rtl/pge_sqrt.sv
// iterative integer square root, two radicand bits per cycle
`default_nettype none
module pge_sqrt (
  input  wire                    clk,
  input  wire                    rst_n,
  input  pge_pkg::pge_sqrt_req_t req,
  output pge_pkg::pge_sqrt_rsp_t rsp
);
  import pge_pkg::*;

  logic              run_r;
  logic              done_r;
  logic [SQRT_W-1:0] bit_r;
  logic [SQRT_W-1:0] rem_r;
  logic [SQRT_W-1:0] res_r;
  logic [SQRT_W-1:0] sum_s;
  logic              fit_s;

  assign sum_s = res_r + bit_r;
  assign fit_s = rem_r >= sum_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !run_r) begin
        run_r <= 1'b1;
        bit_r <= {2'b01, {(SQRT_W-2){1'b0}}};
      end else if (run_r) begin
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !run_r) begin
      rem_r <= req.rad;
      res_r <= '0;
    end else if (run_r) begin
      if (fit_s) begin
        rem_r <= rem_r - sum_s;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[ROOT_W-1:0];

endmodule
`default_nettype wire

### verif/pge_checker.sv
// result checker for the pairwise gravity euler step block: predicts and compares each word
`timescale 1ns / 100ps
module pge_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire               busy,
  input  pge_pkg::pge_in_t  in_data,
  input  wire               out_valid,
  input  pge_pkg::pge_out_t out_data,
  input  wire               cfg_we,
  input  wire [31:0]        cfg_wdata,
  output int                fail_count,
  output int                pending
);
  import pge_pkg::*;

  localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint S32_HI = 64'sh7FFF_FFFF;
  localparam longint S32_LO = -S32_HI - 1;

  logic [31:0] grav_k;
  logic [31:0] mass_tab [BODY_COUNT];
  longint      px [BODY_COUNT];
  longint      py [BODY_COUNT];
  longint      vx [BODY_COUNT];
  longint      vy [BODY_COUNT];
  longint      ax [BODY_COUNT];
  longint      ay [BODY_COUNT];
  bit          clipped;
  pge_out_t    expected_words [$];

  assign pending = expected_words.size();

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) begin
      clipped = 1'b1;
      return lo;
    end
    if (v > hi) begin
      clipped = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // floor(a*b/c), capped
  function automatic longint unsigned scaled_quot(input longint unsigned a,
      input longint unsigned b, input longint unsigned c, input longint unsigned cap);
    logic [127:0] prod;
    logic [127:0] q;
    prod = a * 128'(b);
    if (prod[127:64] >= c) begin
      clipped = 1'b1;
      return cap;
    end
    q = prod / c;
    if (q[63:0] > cap) begin
      clipped = 1'b1;
      return cap;
    end
    return q[63:0];
  endfunction

  function automatic longint pull_term(input longint unsigned gm, input longint d,
      input longint unsigned r2, input longint unsigned r);
    longint unsigned mag;
    longint unsigned s;
    longint unsigned a;
    mag = (d < 0) ? -d : d;
    s = scaled_quot(gm, mag, r2, 64'h7FFF_FFFF_FFFF_FFFF);
    a = scaled_quot(s, 64'd65536, r, ACC_HI);
    return (d < 0) ? -longint'(a) : longint'(a);
  endfunction

  function automatic longint times_dt(input longint v, input longint unsigned dt);
    longint unsigned mag;
    longint p;
    mag = (v < 0) ? -v : v;
    p = longint'((mag * dt) >> 16);
    return (v < 0) ? -p : p;
  endfunction

  task automatic predict_word(input pge_in_t w);
    int i;
    int j;
    longint dx;
    longint dy;
    longint unsigned r2;
    longint unsigned r;
    longint unsigned g1;
    longint unsigned g2;
    longint t1;
    longint t2;
    longint t3;
    longint t4;
    longint unsigned dt;
    pge_out_t e;
    i = w.first_index % BODY_COUNT;
    j = w.second_index % BODY_COUNT;
    clipped = 1'b0;
    e.status = STATUS_OK;
    case (w.mode)
      MODE_LOAD: begin
        mass_tab[i] = w.load_mass;
        px[i] = w.load_pos_x;
        py[i] = w.load_pos_y;
        vx[i] = w.load_vel_x;
        vy[i] = w.load_vel_y;
        ax[i] = 0;
        ay[i] = 0;
      end
      MODE_PAIR: begin
        dx = clip(px[j] - px[i], -S32_HI, S32_HI);
        dy = clip(py[j] - py[i], -S32_HI, S32_HI);
        if (i == j || (dx == 0 && dy == 0)) begin
          e.status = STATUS_COINCIDENT;
          clipped = 1'b0;
        end else begin
          r2 = longint'(dx * dx) + longint'(dy * dy);
          r = int_sqrt(r2);
          g1 = 64'(grav_k) * 64'(mass_tab[j]);
          g2 = 64'(grav_k) * 64'(mass_tab[i]);
          t1 = pull_term(g1, dx, r2, r);
          t2 = pull_term(g1, dy, r2, r);
          t3 = pull_term(g2, -dx, r2, r);
          t4 = pull_term(g2, -dy, r2, r);
          ax[i] = clip(ax[i] + t1, ACC_LO, ACC_HI);
          ay[i] = clip(ay[i] + t2, ACC_LO, ACC_HI);
          ax[j] = clip(ax[j] + t3, ACC_LO, ACC_HI);
          ay[j] = clip(ay[j] + t4, ACC_LO, ACC_HI);
        end
      end
      MODE_STEP: begin
        dt = w.time_step;
        vx[i] = clip(vx[i] + times_dt(ax[i], dt), S32_LO, S32_HI);
        vy[i] = clip(vy[i] + times_dt(ay[i], dt), S32_LO, S32_HI);
        ax[i] = 0;
        ay[i] = 0;
        px[i] = clip(px[i] + times_dt(vx[i], dt), S32_LO, S32_HI);
        py[i] = clip(py[i] + times_dt(vy[i], dt), S32_LO, S32_HI);
      end
      default: ;
    endcase
    if (e.status == STATUS_OK && clipped) e.status = STATUS_SATURATED;
    e.body_index = i[5:0];
    e.pos_x = px[i][31:0];
    e.pos_y = py[i][31:0];
    e.vel_x = vx[i][31:0];
    e.vel_y = vy[i][31:0];
    expected_words.push_back(e);
  endtask

  always @(posedge clk) begin
    pge_out_t e;
    if (!rst_n) begin
      grav_k <= 32'd65536;
      for (int k = 0; k < BODY_COUNT; k++) begin
        ax[k] = 0;
        ay[k] = 0;
      end
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) grav_k <= cfg_wdata;
      if (start && !busy) predict_word(in_data);
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected word: got %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (out_data.body_index !== e.body_index || out_data.pos_x !== e.pos_x ||
              out_data.pos_y !== e.pos_y || out_data.vel_x !== e.vel_x ||
              out_data.vel_y !== e.vel_y || out_data.status !== e.status) begin
            $display("%0t word mismatch: expected idx %0d p %h %h v %h %h st %0d",
                     $time, e.body_index, e.pos_x, e.pos_y, e.vel_x, e.vel_y, e.status);
            $display("%0t                got      idx %0d p %h %h v %h %h st %0d",
                     $time, out_data.body_index, out_data.pos_x, out_data.pos_y,
                     out_data.vel_x, out_data.vel_y, out_data.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### verif/testbench.sv
// top of the testbench: clock, reset, stimulus and the final verdict
`timescale 1ns / 100ps
module testbench;
  import pge_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  pge_in_t     in_data;
  logic        out_valid;
  pge_out_t    out_data;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          pending;
  bit          loaded_map [BODY_COUNT];
  int          loaded_list [$];
  bit          no_gaps;

  pairwise_gravity_euler_step u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  pge_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("pairwise_gravity_euler_step: mismatch");
    $finish;
  end

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    if ($urandom_range(0, 9) == 0) return $urandom;
    v = $urandom & ((32'd1 << $urandom_range(8, 26)) - 1);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic pge_in_t rand_word(input logic [1:0] mode, input int i, input int j);
    pge_in_t w;
    w.mode = mode;
    w.first_index = i[5:0];
    w.second_index = j[5:0];
    w.load_mass = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 1 << 22);
    w.load_pos_x = rand_coord();
    w.load_pos_y = rand_coord();
    w.load_vel_x = rand_coord();
    w.load_vel_y = rand_coord();
    w.time_step = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4096));
    return w;
  endfunction

  // start stays high into the next word when there is no gap
  task automatic send(input pge_in_t w);
    if (w.mode == MODE_LOAD && !loaded_map[w.first_index]) begin
      loaded_map[w.first_index] = 1'b1;
      loaded_list.push_back(w.first_index);
    end
    // a gap begins once the block is free again
    if (!no_gaps && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
      repeat ($urandom_range(0, 5)) @(posedge clk);
    end
    in_data <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_gravity(input logic [31:0] g);
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_body();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  task automatic random_word();
    int r;
    pge_in_t w;
    r = $urandom_range(0, 99);
    if (r < 15) w = rand_word(MODE_LOAD, $urandom_range(0, 63), $urandom_range(0, 63));
    else if (r < 55) w = rand_word(MODE_PAIR, pick_body(), pick_body());
    else if (r < 82) w = rand_word(MODE_STEP, pick_body(), $urandom_range(0, 63));
    else w = rand_word(MODE_READ, pick_body(), $urandom_range(0, 63));
    send(w);
  endtask

  initial begin
    pge_in_t w;
    logic [31:0] gravities [5];
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    no_gaps = 1'b0;
    gravities = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0};
    gravities[4] = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_gravity(32'd65536);

    // extremes: far apart, same body, coincident bodies, saturating step
    w = rand_word(MODE_LOAD, 0, 5);
    w.load_mass = 32'hFFFF_FFFF;
    w.load_pos_x = 32'h7FFF_FFFF;
    w.load_pos_y = 32'h7FFF_FFFF;
    w.load_vel_x = 32'h7FFF_FFFF;
    w.load_vel_y = 32'h8000_0000;
    send(w);
    w = rand_word(MODE_LOAD, 63, 0);
    w.load_mass = 32'd0;
    w.load_pos_x = 32'h8000_0000;
    w.load_pos_y = 32'h8000_0000;
    w.load_vel_x = 32'd0;
    w.load_vel_y = 32'd0;
    send(w);
    send(rand_word(MODE_PAIR, 0, 63));
    send(rand_word(MODE_PAIR, 0, 0));
    w = rand_word(MODE_LOAD, 1, 2);
    w.load_mass = 32'd65536;
    w.load_pos_x = 32'h7FFF_FFFF;
    w.load_pos_y = 32'h7FFF_FFFF;
    send(w);
    send(rand_word(MODE_PAIR, 1, 0));
    w = rand_word(MODE_LOAD, 2, 0);
    w.load_mass = 32'd65536;
    w.load_pos_x = 32'd65536;
    w.load_pos_y = 32'd0;
    send(w);
    w = rand_word(MODE_LOAD, 3, 0);
    w.load_mass = 32'd3 << 16;
    w.load_pos_x = 32'd0;
    w.load_pos_y = 32'd3 << 16;
    send(w);
    send(rand_word(MODE_PAIR, 2, 3));
    w = rand_word(MODE_STEP, 2, 63);
    w.time_step = 16'hFFFF;
    send(w);
    w = rand_word(MODE_STEP, 3, 0);
    w.time_step = 16'd0;
    send(w);
    w = rand_word(MODE_STEP, 0, 0);
    w.time_step = 16'hFFFF;
    send(w);
    send(rand_word(MODE_READ, 2, 63));
    send(rand_word(MODE_READ, 63, 42));

    for (int ph = 0; ph < 5; ph++) begin
      write_gravity(gravities[ph]);
      no_gaps = (ph == 2);
      for (int n = 0; n < 120; n++) random_word();
    end

    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("pairwise_gravity_euler_step: match");
    end else begin
      $display("pairwise_gravity_euler_step: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pge_pkg.sv
rtl/pge_div.sv
rtl/pge_sqrt.sv
rtl/pairwise_gravity_euler_step.sv
verif/pge_checker.sv
verif/testbench.sv
